### src/assert_macros.svh
// assertion macros used by the text console writer back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled during reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("text console writer assertion failed");

// condition that must never be true
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   `ASSERT_CLK(lbl, clk, rst, !(cond))

`endif

### src/ctw_pkg.sv
// text console writer package: field widths, character codes, queue entry type
// no dependencies
package ctw_pkg;

   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int LOC_W       = 11;
   localparam int ADDR_W      = 12;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int TAB_STEP    = 8;

   localparam logic [ATTR_W-1:0] STD_ATTR   = 8'h0F;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

   localparam logic [CHAR_W-1:0] CHAR_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

   localparam logic OP_PUT   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic REG_TEXT_ATTR = 1'b0;

   typedef struct packed {
      logic              do_write;
      logic              do_scroll;
      logic              do_clear;
      logic              has_result;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] cell_word;
      logic [ATTR_W-1:0] attr;
      logic [LOC_W-1:0]  location;
   } ctw_entry_type;

endpackage

### src/text_console_writer_top.sv
// text console writer top level: front, queue and back
// uses ctw_pkg, ctw_front, ctw_queue, ctw_back
//
// usage
// - req channel: opcode (put or clear) and char_code, valid/stall handshake
// - rsp channel: cursor_location after each put; a clear gives no transaction
// - csr port: apb-style, register text_attribute at byte address 0
// - a put without scroll: queued, then loaded into the result register; one put
//   per cycle sustained through the two-entry queue while rsp_stall is low
// - a put that scrolls or a clear: the back sweeps the cell store, one cell a
//   cycle, with input taken until the queue fills
// - the scroll and clear sweeps use the store's one write and one read port
// - reset: cursor homed, text_attribute 0x0F, then a clearing pass blanks the
//   store while req_stall stays high; csr writes are taken during the pass
// - rsp_stall holds the result register; the queue keeps accepting puts until
//   it fills, then req_stall rises
module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [ctw_pkg::CHAR_W-1:0]    req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ctw_pkg::LOC_W-1:0]     rsp_cursor_location,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ctw_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [ctw_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [ctw_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   logic                   init_busy;
   logic                   q_push;
   ctw_pkg::ctw_entry_type q_push_entry;
   logic                   q_full;
   logic                   q_pop;
   ctw_pkg::ctw_entry_type q_head;
   logic                   q_empty;

   ctw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .init_busy     (init_busy),
      .q_push        (q_push),
      .q_push_entry  (q_push_entry),
      .q_full        (q_full)
   );

   ctw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   ctw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .init_busy           (init_busy),
      .q_pop               (q_pop),
      .q_head              (q_head),
      .q_empty             (q_empty),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_location (rsp_cursor_location)
   );

endmodule

### src/ctw_front.sv
// text console writer front: accepts transactions, tracks the cursor, holds the
// attribute register and csr port, and queues store operations; uses ctw_pkg
module ctw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [ctw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ctw_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [ctw_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [ctw_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready,
   input  logic                              init_busy,
   output logic                              q_push,
   output ctw_pkg::ctw_entry_type            q_push_entry,
   input  logic                              q_full
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CALC_W = COL_W + 1;
   localparam int AW     = ctw_pkg::ADDR_W;

   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [ctw_pkg::ATTR_W-1:0]    attr_ff, attr_in;

   logic                          accept;
   logic                          csr_write;
   logic                          csr_hit;
   logic [CALC_W-1:0]             col_calc;
   logic                          newline;
   logic                          printable;
   logic                          wrap;
   logic                          last_row;
   logic [COL_W-1:0]              col_next;
   logic [ROW_W-1:0]              row_next;
   logic [AW-1:0]                 pos;
   logic [AW-1:0]                 loc_next;

   assign req_stall  = init_busy || q_full;
   assign accept     = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[ctw_pkg::CSR_AW-1] == ctw_pkg::REG_TEXT_ATTR);
   assign csr_prdata = csr_hit ? {{(ctw_pkg::CSR_DW - ctw_pkg::ATTR_W){1'b0}}, attr_ff}
                               : '0;

   always_comb begin
      col_calc  = CALC_W'(col_ff);
      newline   = 1'b0;
      printable = 1'b0;
      case (req_char_code)
         ctw_pkg::CHAR_CR: begin
            col_calc = '0;
         end
         ctw_pkg::CHAR_BS: begin
            if (col_ff != '0) begin
               col_calc = CALC_W'(col_ff) - CALC_W'(1);
            end
         end
         ctw_pkg::CHAR_TAB: begin
            col_calc = (CALC_W'(col_ff) + CALC_W'(ctw_pkg::TAB_STEP))
                       & ~CALC_W'(ctw_pkg::TAB_STEP - 1);
         end
         ctw_pkg::CHAR_LF: begin
            col_calc = '0;
            newline  = 1'b1;
         end
         default: begin
            col_calc  = CALC_W'(col_ff) + CALC_W'(1);
            printable = 1'b1;
         end
      endcase
   end

   assign wrap     = newline || (col_calc >= CALC_W'(COLUMNS));
   assign last_row = (row_ff == ROW_W'(ROWS - 1));
   assign col_next = wrap ? '0 : col_calc[COL_W-1:0];
   assign row_next = (wrap && !last_row) ? row_ff + ROW_W'(1) : row_ff;
   assign pos      = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign loc_next = AW'(row_next) * AW'(COLUMNS) + AW'(col_next);

   always_comb begin
      q_push_entry = '0;
      if (req_opcode == ctw_pkg::OP_CLEAR) begin
         q_push_entry.do_clear = 1'b1;
         q_push_entry.attr     = ctw_pkg::STD_ATTR;
      end else begin
         q_push_entry.do_write   = printable;
         q_push_entry.do_scroll  = wrap && last_row;
         q_push_entry.has_result = 1'b1;
         q_push_entry.addr       = pos;
         q_push_entry.cell_word  = {attr_ff, req_char_code};
         q_push_entry.attr       = attr_ff;
         q_push_entry.location   = loc_next[ctw_pkg::LOC_W-1:0];
      end
   end

   assign q_push = accept;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      attr_in = attr_ff;
      if (accept) begin
         if (req_opcode == ctw_pkg::OP_CLEAR) begin
            col_in  = '0;
            row_in  = '0;
            attr_in = ctw_pkg::STD_ATTR;
         end else begin
            col_in = col_next;
            row_in = row_next;
         end
      end else if (csr_write && csr_hit) begin
         attr_in = csr_pwdata[ctw_pkg::ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         attr_ff <= ctw_pkg::STD_ATTR;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         attr_ff <= attr_in;
      end
   end

endmodule

### src/ctw_queue.sv
// text console writer queue between front and back
// uses ctw_pkg for the entry type and depth
module ctw_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ctw_pkg::ctw_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output ctw_pkg::ctw_entry_type head,
   output logic                   empty
);

   localparam int DEPTH = ctw_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ctw_pkg::ctw_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/ctw_back.sv
// text console writer back: owns the cell store, runs writes, scroll and clear
// sweeps, and the result register; uses ctw_pkg and assert_macros.svh
`include "assert_macros.svh"

module ctw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        init_busy,
   output logic                        q_pop,
   input  ctw_pkg::ctw_entry_type      q_head,
   input  logic                        q_empty,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ctw_pkg::LOC_W-1:0]   rsp_cursor_location
);

   localparam int CELLS       = COLUMNS * ROWS;
   localparam int SHIFT_CELLS = (ROWS - 1) * COLUMNS;
   localparam int CELL_AW     = $clog2(CELLS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CLEAR  = 3'b010,
      ST_SCROLL = 3'b100
   } back_state_type;

   back_state_type                  state_ff, state_in;
   logic [CELL_AW-1:0]              idx_ff, idx_in;
   logic                            init_ff, init_in;
   logic [ctw_pkg::ATTR_W-1:0]      attr_ff, attr_in;
   logic                            has_res_ff, has_res_in;
   logic [ctw_pkg::LOC_W-1:0]       loc_ff, loc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ctw_pkg::LOC_W-1:0]       rsp_loc_ff, rsp_loc_in;

   logic [ctw_pkg::CELL_W-1:0]      cell_store_ff [CELLS];
   logic [ctw_pkg::CELL_W-1:0]      rd_data_ff;

   logic                            we;
   logic [CELL_AW-1:0]              wa;
   logic [ctw_pkg::CELL_W-1:0]      wd;
   logic [CELL_AW-1:0]              ra;
   logic [CELL_AW:0]                ra_ahead;
   logic                            out_free;
   logic                            last_idx;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty && out_free;
   assign last_idx  = (idx_ff == CELL_AW'(CELLS - 1));
   assign ra_ahead  = {1'b0, idx_ff} + (CELL_AW + 1)'(COLUMNS + 1);
   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cursor_location = rsp_loc_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      init_in      = init_ff;
      attr_in      = attr_ff;
      has_res_in   = has_res_ff;
      loc_in       = loc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_loc_in   = rsp_loc_ff;
      we           = 1'b0;
      wa           = '0;
      wd           = '0;
      ra           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               attr_in    = q_head.attr;
               has_res_in = q_head.has_result;
               loc_in     = q_head.location;
               if (q_head.do_write) begin
                  we = 1'b1;
                  wa = q_head.addr[CELL_AW-1:0];
                  wd = q_head.cell_word;
               end
               if (q_head.do_clear) begin
                  state_in = ST_CLEAR;
                  idx_in   = '0;
               end else if (q_head.do_scroll) begin
                  state_in = ST_SCROLL;
                  idx_in   = '0;
                  ra       = CELL_AW'(COLUMNS);
               end else if (q_head.has_result) begin
                  rsp_valid_in = 1'b1;
                  rsp_loc_in   = q_head.location;
               end
            end
         end
         ST_CLEAR: begin
            we = 1'b1;
            wa = idx_ff;
            wd = {ctw_pkg::STD_ATTR, ctw_pkg::BLANK_CHAR};
            if (last_idx) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end else begin
               idx_in = idx_ff + CELL_AW'(1);
            end
         end
         ST_SCROLL: begin
            we = 1'b1;
            wa = idx_ff;
            wd = (idx_ff < CELL_AW'(SHIFT_CELLS)) ? rd_data_ff
                                                  : {attr_ff, ctw_pkg::BLANK_CHAR};
            if (ra_ahead < (CELL_AW + 1)'(CELLS)) begin
               ra = ra_ahead[CELL_AW-1:0];
            end
            if (last_idx) begin
               state_in = ST_IDLE;
               if (has_res_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_loc_in   = loc_ff;
               end
            end else begin
               idx_in = idx_ff + CELL_AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         init_ff      <= 1'b1;
         has_res_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         has_res_ff   <= has_res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      attr_ff    <= attr_in;
      loc_ff     <= loc_in;
      rsp_loc_ff <= rsp_loc_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         cell_store_ff[wa] <= wd;
      end
      rd_data_ff <= cell_store_ff[ra];
   end

   `ASSERT_CLK(a_busy_out_empty, clock, reset, (state_ff != ST_IDLE) |-> !rsp_valid_ff)
   `ASSERT_CLK(a_idx_range, clock, reset, (state_ff != ST_IDLE) |-> (idx_ff <= CELL_AW'(CELLS - 1)))
   `ASSERT_CLK(a_init_in_clear, clock, reset, init_ff |-> (state_ff == ST_CLEAR))
   `ASSERT_NEVER(a_no_pop_in_init, clock, reset, init_ff && q_pop)

endmodule

### test/testbench.sv
// testbench for text_console_writer_top: cursor predictor, handshake driver and result monitor
// drives puts and clears with random bursts and stalls, checks each cursor_location transaction
// depends on ctw_pkg and text_console_writer_top
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int SWEEP_CYCLES = CELLS + 1;
   localparam int SETTLE_CYCLES = 3 * SWEEP_CYCLES + 64;
   localparam int MAX_GAP = 6;
   localparam int LONG_HOLD = 400;
   localparam int ITEM_CAP = 1800;
   localparam longint CYCLE_LIMIT =
      3 * (longint'(ITEM_CAP) * (SWEEP_CYCLES + MAX_GAP + 16)
           + 5 * SETTLE_CYCLES + LONG_HOLD + CELLS);
   localparam logic [ctw_pkg::CSR_AW-1:0] TEXT_ATTR_ADDR =
      ctw_pkg::CSR_AW'(4 * ctw_pkg::REG_TEXT_ATTR);

   typedef struct packed {
      logic                       opcode;
      logic [ctw_pkg::CHAR_W-1:0] char_code;
   } console_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = ctw_pkg::OP_PUT;
   logic [ctw_pkg::CHAR_W-1:0] req_char_code = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ctw_pkg::LOC_W-1:0] rsp_cursor_location;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ctw_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [ctw_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [ctw_pkg::CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   console_op_type queued_ops[$];
   logic [ctw_pkg::LOC_W-1:0] expected_locations[$];

   int unsigned col_now = 0;
   int unsigned row_now = 0;
   logic [ctw_pkg::ATTR_W-1:0] attr_now = ctw_pkg::STD_ATTR;

   int unsigned ops_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   bit long_hold_done = 1'b0;
   logic [15:0] stall_phase = '0;
   longint cycle_count = 0;

   text_console_writer_top #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cursor_location(rsp_cursor_location),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void note_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   function automatic void line_feed();
      row_now++;
      if (row_now >= ROWS) begin
         row_now = ROWS - 1;
      end
   endfunction

   // cursor movement for one accepted transaction
   function automatic void advance_cursor(console_op_type op);
      if (op.opcode == ctw_pkg::OP_CLEAR) begin
         attr_now = ctw_pkg::STD_ATTR;
         col_now = 0;
         row_now = 0;
      end else begin
         case (op.char_code)
            ctw_pkg::CHAR_CR: begin
               col_now = 0;
            end
            ctw_pkg::CHAR_BS: begin
               if (col_now > 0) col_now--;
            end
            ctw_pkg::CHAR_TAB: begin
               col_now = (col_now + ctw_pkg::TAB_STEP) & ~(ctw_pkg::TAB_STEP - 1);
            end
            ctw_pkg::CHAR_LF: begin
               col_now = 0;
               line_feed();
            end
            default: begin
               col_now++;
            end
         endcase
         if (col_now >= COLUMNS) begin
            col_now = 0;
            line_feed();
         end
         expected_locations.push_back(ctw_pkg::LOC_W'(row_now * COLUMNS + col_now));
      end
   endfunction

   function automatic console_op_type random_op();
      console_op_type op;
      int unsigned pick;
      pick = $urandom_range(999);
      op.opcode = ctw_pkg::OP_PUT;
      op.char_code = ctw_pkg::CHAR_W'($urandom_range(255));
      if (pick < 5) op.opcode = ctw_pkg::OP_CLEAR;
      else if (pick < 90) op.char_code = ctw_pkg::CHAR_LF;
      else if (pick < 160) op.char_code = ctw_pkg::CHAR_TAB;
      else if (pick < 210) op.char_code = ctw_pkg::CHAR_BS;
      else if (pick < 250) op.char_code = ctw_pkg::CHAR_CR;
      return op;
   endfunction

   // sender: bursts of random length, random gaps
   always @(posedge clock) begin
      console_op_type next_op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_cursor('{req_opcode, req_char_code});
            ops_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_ops.size() > 0) begin
               next_op = queued_ops.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_op.opcode;
               req_char_code <= next_op.char_code;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern plus one long hold-off
   always @(posedge clock) begin
      stall_phase <= stall_phase + 16'd1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && ops_accepted >= 300) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_phase[9:7])
            3'd0, 3'd1: rsp_stall <= 1'b0;
            3'd2: rsp_stall <= ($urandom_range(1) == 0);
            3'd3: rsp_stall <= ($urandom_range(3) == 0);
            3'd4: rsp_stall <= stall_phase[3];
            3'd5: rsp_stall <= ($urandom_range(3) != 0);
            default: rsp_stall <= (stall_phase[2:0] == 3'd0);
         endcase
      end
   end

   always @(posedge clock) begin
      logic [ctw_pkg::LOC_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_locations.size() == 0) begin
            note_mismatch("unexpected cursor_location", -1, rsp_cursor_location);
         end else begin
            want = expected_locations.pop_front();
            if (rsp_cursor_location !== want) begin
               note_mismatch("cursor_location", want, rsp_cursor_location);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_console_writer_top verification failed");
         $finish;
      end
   end

   task automatic write_attribute(input logic [ctw_pkg::ATTR_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TEXT_ATTR_ADDR;
      csr_pwdata <= ctw_pkg::CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      attr_now = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_attribute();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= TEXT_ATTR_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[ctw_pkg::ATTR_W-1:0] !== attr_now) begin
         note_mismatch("text_attribute", attr_now, csr_prdata[ctw_pkg::ATTR_W-1:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain_and_settle();
      while (queued_ops.size() > 0 || req_valid) @(posedge clock);
      while (expected_locations.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [ctw_pkg::ATTR_W-1:0] value);
      check_attribute();
      write_attribute(value);
      check_attribute();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      configure(8'h00);

      queued_ops.push_back('{ctw_pkg::OP_PUT, 8'h00});
      queued_ops.push_back('{ctw_pkg::OP_PUT, 8'hFF});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_BS});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_BS});
      // backspace at column zero stays put
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_BS});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_TAB});
      queued_ops.push_back('{ctw_pkg::OP_PUT, 8'h7E});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_TAB});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_CR});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_LF});
      queued_ops.push_back('{ctw_pkg::OP_PUT, 8'h41});
      queued_ops.push_back('{ctw_pkg::OP_CLEAR, 8'hFF});
      queued_ops.push_back('{ctw_pkg::OP_PUT, 8'h55});
      queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_CR});
      // tabs up to the last tab stop, the tenth wraps to the next row
      for (int i = 0; i < 10; i++) begin
         queued_ops.push_back('{ctw_pkg::OP_PUT, ctw_pkg::CHAR_TAB});
      end
      queued_ops.push_back('{ctw_pkg::OP_CLEAR, 8'h00});
      drain_and_settle();

      configure(8'hFF);
      for (int i = 0; i < 600; i++) queued_ops.push_back(random_op());
      drain_and_settle();

      configure(ctw_pkg::ATTR_W'($urandom_range(1, 254)));
      for (int i = 0; i < 600; i++) queued_ops.push_back(random_op());
      drain_and_settle();

      configure(8'h4F);
      for (int i = 0; i < 550; i++) queued_ops.push_back(random_op());
      drain_and_settle();
      check_attribute();

      if (mismatch_count == 0) begin
         $display("text_console_writer_top verification clean");
      end else begin
         $display("text_console_writer_top verification failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/ctw_pkg.sv
src/ctw_front.sv
src/ctw_queue.sv
src/ctw_back.sv
src/text_console_writer_top.sv
test/testbench.sv
